// ===== rtl/core/deadline_sorted_queue_macros.svh =====
// Assertion helpers used by the queue RTL.
`ifndef DEADLINE_SORTED_QUEUE_MACROS_SVH
`define DEADLINE_SORTED_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DSQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication, checked outside reset.
`define DSQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== rtl/core/dsq_pkg.sv =====
package dsq_pkg;

  localparam int DEPTH_DEFAULT = 16;

  localparam int REQ_W  = 2;
  localparam int TASK_W = 16;
  localparam int DL_W   = 32;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 5;

  // Request codes; code 3 is unused and leaves the queue alone
  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT    = 2'd0,
    REQ_POP_EARLY = 2'd1,
    REQ_POP_LATE  = 2'd2
  } req_type_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // One queued entry
  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [DL_W-1:0]   deadline;
  } entry_t;

  // Broadcast from the control to every cell
  typedef struct packed {
    logic   ins_en;
    logic   pop_en;
    entry_t item;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/dsq_req_if.sv =====
interface dsq_req_if import dsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [REQ_W-1:0]  req_type;
  logic [TASK_W-1:0] task_id;
  logic [DL_W-1:0]   deadline_in;

  modport source (output valid, output req_type, output task_id, output deadline_in,
                  input ready);
  modport sink   (input valid, input req_type, input task_id, input deadline_in,
                  output ready);
endinterface

// ===== rtl/core/dsq_rsp_if.sv =====
interface dsq_rsp_if import dsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ST_W-1:0]   status;
  logic [TASK_W-1:0] out_task_id;
  logic [DL_W-1:0]   out_deadline;
  logic [OCC_W-1:0]  occupancy;

  modport source (output valid, output status, output out_task_id, output out_deadline,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_task_id, input out_deadline,
                  input occupancy, output ready);
endinterface

// ===== rtl/core/dsq_cell.sv =====
// One slot of the sorted chain. Holds an entry and trades it with its neighbors.
module dsq_cell import dsq_pkg::*; (
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       left_take,
  input  entry_t     left_data,
  input  entry_t     right_data,
  output logic       take,
  output entry_t     data
);

  // This slot lies at or behind the insert point: empty, or strictly later deadline
  assign take = !occ || (data.deadline > ctrl.item.deadline);

  // Insert shifts everything behind the insert point one slot back;
  // pop of the earliest shifts everything one slot forward
  always_ff @(posedge clk) begin
    if (ctrl.ins_en && take) begin
      data <= left_take ? left_data : ctrl.item;
    end else if (ctrl.pop_en) begin
      data <= right_data;
    end
  end

endmodule

// ===== rtl/core/deadline_sorted_queue.sv =====
// Earliest-deadline-first queue of up to DEPTH (task id, deadline) entries, kept in
// ascending deadline order in a chain of cells; equal deadlines leave the head first in,
// first out. For every request (insert, pop earliest, pop latest) all cells compare their
// deadline with the new one in parallel, so a request can be accepted on every clock that
// the output register is free, and its result appears in the output register on the next
// cycle. A new request is accepted whenever the output register is empty or being
// drained. An insert into a full queue returns status full; a pop from an empty queue
// returns status empty. Occupancy reports the count after the request, modulo 32.
`include "deadline_sorted_queue_macros.svh"

module deadline_sorted_queue import dsq_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  dsq_req_if.sink    req,
  dsq_rsp_if.source  rsp
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic          accept;
  logic          full;
  logic          empty;

  logic [DEPTH-1:0] occ;
  logic [DEPTH-1:0] last;
  logic [DEPTH-1:0] take;
  logic [DEPTH-1:0] left_take;
  entry_t           cdata      [DEPTH];
  entry_t           left_data  [DEPTH];
  entry_t           right_data [DEPTH];

  cell_ctrl_t ctrl;
  entry_t     latest;
  req_type_t  rtype;

  status_t           status_next;
  logic [TASK_W-1:0] task_next;
  logic [DL_W-1:0]   dl_next;

  // Output register; a new item enters when it is empty or being taken
  assign req.ready = !rsp.valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign rtype = req_type_t'(req.req_type);

  // Cell chain with neighbor wiring
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = (CW'(i) < count);

    if (i == 0) begin : g_head
      assign left_take[i] = 1'b0;
      assign left_data[i] = '0;
    end else begin : g_body
      assign left_take[i] = take[i-1];
      assign left_data[i] = cdata[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_data[i] = '0;
      assign last[i]       = occ[i];
    end else begin : g_mid
      assign right_data[i] = cdata[i+1];
      assign last[i]       = occ[i] && !occ[i+1];
    end

    dsq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .left_take  (left_take[i]),
      .left_data  (left_data[i]),
      .right_data (right_data[i]),
      .take       (take[i]),
      .data       (cdata[i])
    );
  end

  // Latest entry: one-hot select of the last occupied cell
  always_comb begin
    latest = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (last[i]) latest = latest | cdata[i];
    end
  end

  // Request decode
  always_comb begin
    ctrl.ins_en           = 1'b0;
    ctrl.pop_en           = 1'b0;
    ctrl.item.task_id     = req.task_id;
    ctrl.item.deadline    = req.deadline_in;
    count_next            = count;
    status_next           = ST_OK;
    task_next             = '0;
    dl_next               = '0;
    unique case (rtype)
      REQ_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctrl.ins_en = accept;
          count_next  = count + CW'(1);
        end
      end
      REQ_POP_EARLY: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctrl.pop_en = accept;
          count_next  = count - CW'(1);
          task_next   = cdata[0].task_id;
          dl_next     = cdata[0].deadline;
        end
      end
      REQ_POP_LATE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
          task_next  = latest.task_id;
          dl_next    = latest.deadline;
        end
      end
      default: begin
      end
    endcase
  end

  // Count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (accept) count <= count_next;
      if (accept) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.status       <= status_next;
      rsp.out_task_id  <= task_next;
      rsp.out_deadline <= dl_next;
      rsp.occupancy    <= OCC_W'(count_next);
    end
  end

  `DSQ_ASSERT_NOW(a_count_max, 1'b1, count <= CW'(DEPTH))
  `DSQ_ASSERT_NOW(a_full_status, rsp.valid && rsp.status == ST_FULL, full)
  `DSQ_ASSERT_NOW(a_sorted_head, count >= CW'(2), cdata[0].deadline <= cdata[1].deadline)
  `DSQ_ASSERT_NEXT(a_insert_grows, accept && rtype == REQ_INSERT && !full,
                   count == $past(count) + CW'(1))
  `DSQ_ASSERT_NEXT(a_pop_shrinks,
                   accept && (rtype == REQ_POP_EARLY || rtype == REQ_POP_LATE) && !empty,
                   count == $past(count) - CW'(1))

endmodule
